// ----- hw/rtl/fce_pkg.sv -----
`timescale 1ns / 1ps
// Package for the Fourier curve evaluator: sizes, constants, payload structs,
// sequencer states, quarter-wave sine table and rounding helpers.
// No dependencies.
package fce_pkg;

  localparam int MAX_HARM    = 16;
  localparam int HARM_ADDR_W = $clog2(MAX_HARM);
  localparam int PHASE_BITS  = 16;
  localparam int SINE_DEPTH  = 1024;
  localparam int POS_W       = $clog2(4 * SINE_DEPTH);
  localparam int QIDX_W      = $clog2(SINE_DEPTH + 1);
  localparam int COEF_W      = 32;
  localparam int ROW_W       = 3 * COEF_W;
  localparam int ACC_W       = 56;

  localparam logic [63:0] HALF_PI_Q31  = 64'd3373259426;
  localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
  localparam logic [63:0] FOUR_PI2_W   = (HALF_PI_Q31 * HALF_PI_Q31 + 64'd2147483648) >> 32;
  localparam logic [31:0] FOUR_PI2_Q26 = FOUR_PI2_W[31:0];
  localparam int TAN_SHIFT = 37;
  localparam int ACC_SHIFT = 34;

  typedef enum logic [0:0] {
    MODE_WRITE = 1'b0,
    MODE_EVAL  = 1'b1
  } mode_t;

  typedef struct packed {
    logic              mode;
    logic [4:0]        harmonic;
    logic              is_sine;
    logic signed [31:0] coef_x;
    logic signed [31:0] coef_y;
    logic signed [31:0] coef_z;
    logic [15:0]       phase;
  } req_t;

  typedef struct packed {
    logic signed [39:0] point_x;
    logic signed [39:0] point_y;
    logic signed [39:0] point_z;
    logic signed [47:0] tangent_x;
    logic signed [47:0] tangent_y;
    logic signed [47:0] tangent_z;
    logic signed [55:0] accel_x;
    logic signed [55:0] accel_y;
    logic signed [55:0] accel_z;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_MUL,
    S_DRAIN,
    S_FLO,
    S_FHI,
    S_FCMB,
    S_OUT
  } state_t;

  typedef logic [30:0] quarter_tab_t [0:SINE_DEPTH];

  function automatic quarter_tab_t build_quarter();
    quarter_tab_t t;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  h;
    logic [63:0]  s;
    logic [63:0]  e;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x  = (64'(i) * HALF_PI_Q31) / SINE_DEPTH;
      x2 = (x * x) >> 31;
      h  = 64'd1 << 31;
      h  = (64'd1 << 31) - ((x2 * h) >> 31) / 156;
      h  = (64'd1 << 31) - ((x2 * h) >> 31) / 110;
      h  = (64'd1 << 31) - ((x2 * h) >> 31) / 72;
      h  = (64'd1 << 31) - ((x2 * h) >> 31) / 42;
      h  = (64'd1 << 31) - ((x2 * h) >> 31) / 20;
      h  = (64'd1 << 31) - ((x2 * h) >> 31) / 6;
      s  = (x * h) >> 31;
      e  = (s + 64'd1) >> 1;
      if (e > 64'd1073741824) e = 64'd1073741824;
      t[i] = e[30:0];
    end
    return t;
  endfunction

  localparam quarter_tab_t QUARTER = build_quarter();

  // quarter-table index for a full-wave position (mirrored in odd quadrants)
  function automatic logic [QIDX_W-1:0] quarter_index(input logic [POS_W-1:0] pos);
    logic [QIDX_W-1:0] r;
    r = {1'b0, pos[POS_W-3:0]};
    return pos[POS_W-2] ? QIDX_W'(SINE_DEPTH) - r : r;
  endfunction

  // round x / 2^sh, half away from zero
  function automatic logic signed [63:0] round_away(input logic signed [63:0] x,
                                                    input int sh);
    logic [63:0] mag;
    logic [63:0] q;
    mag = x[63] ? 64'(-x) : 64'(x);
    q   = (mag + (64'd1 << (sh - 1))) >> sh;
    return x[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [63:0] sat_to(input logic signed [63:0] v, input int w);
    logic signed [63:0] lim;
    logic signed [63:0] r;
    lim = 64'sd1 <<< (w - 1);
    r   = v;
    if (v > lim - 64'sd1) r = lim - 64'sd1;
    if (v < -lim) r = -lim;
    return r;
  endfunction

endpackage

// ----- hw/rtl/fce_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/fourier_curve_evaluator.sv -----
`timescale 1ns / 1ps
// Fourier curve evaluator top level; uses fce_pkg and fce_ram.
// Evaluate request: busy while the harmonics in use (max 16) are summed and scaled,
// then done strobes the result for one cycle; the receiver cannot stall and a new request
// can be accepted in the done cycle. Per harmonic: store/table read, one pass per
// component through four shared 32x32 multipliers; scaling: low/high product, combine.
// Writes leave busy low. Reset clears count, valid bits, constant term.
module fourier_curve_evaluator (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  fce_pkg::req_t    req,
  output logic             done,
  output fce_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [4:0]       cfg_data
);

  fce_pkg::state_t state, state_next;

  logic [4:0] hiu;
  logic [4:0] n_reg;
  logic [4:0] k;
  logic [1:0] c;
  logic [2:0] f;
  logic [15:0] p_reg;
  logic [15:0] pk;

  logic accept, wr_req, ev_req;
  logic slot_ok;
  logic cos_we, sin_we;
  logic [fce_pkg::HARM_ADDR_W-1:0] waddr, raddr;
  logic [fce_pkg::ROW_W-1:0] wrow, cos_row, sin_row;
  logic [fce_pkg::MAX_HARM-1:0] cos_vld, sin_vld;
  logic cos_ok, sin_ok;
  logic signed [31:0] cst [0:2];

  logic [fce_pkg::POS_W-1:0] spos, cpos;
  logic [30:0] sin_mag, cos_mag;
  logic sin_neg, cos_neg;
  logic signed [31:0] sv, cv, a_op, b_op;

  logic mul_en, fin_lo, fin_hi, fin_cmb, out_en;

  logic v1, v2, v3;
  logic [1:0] c1, c2, c3;
  logic [4:0] k1, k2, k3;
  logic [9:0] kk3;
  logic signed [63:0] pr_ac, pr_as, pr_bc, pr_bs;
  logic signed [40:0] t_ac, t_as, t_bc, t_bs;
  logic signed [41:0] s3, d3;
  logic signed [fce_pkg::ACC_W-1:0] accp [0:2];
  logic signed [fce_pkg::ACC_W-1:0] acct [0:2];
  logic signed [fce_pkg::ACC_W-1:0] acca [0:2];
  logic signed [fce_pkg::ACC_W-1:0] kd, kks;

  logic signed [fce_pkg::ACC_W-1:0] fsel;
  logic [fce_pkg::ACC_W-1:0] fmag;
  logic [31:0] fconst;
  logic [63:0] flo;
  logic [55:0] fhi;
  logic [88:0] ffull;
  logic [55:0] fq;
  logic [55:0] qt [0:2];
  logic [55:0] qa [0:2];
  logic nt [0:2];
  logic na [0:2];
  logic [63:0] pt_sat [0:2];
  logic [63:0] tg_sat [0:2];
  logic [63:0] ac_sat [0:2];

  assign accept  = start && !busy;
  assign wr_req  = accept && (req.mode == fce_pkg::MODE_WRITE);
  assign ev_req  = accept && (req.mode == fce_pkg::MODE_EVAL);
  assign slot_ok = (req.harmonic != 5'd0) && (req.harmonic <= 5'(fce_pkg::MAX_HARM));
  assign cos_we  = wr_req && slot_ok && !req.is_sine;
  assign sin_we  = wr_req && slot_ok && req.is_sine;
  assign waddr   = fce_pkg::HARM_ADDR_W'(req.harmonic - 5'd1);
  assign wrow    = {req.coef_z, req.coef_y, req.coef_x};
  assign raddr   = fce_pkg::HARM_ADDR_W'(k - 5'd1);
  assign cfg_ready = !busy;

  fce_ram #(.WIDTH(fce_pkg::ROW_W), .DEPTH(fce_pkg::MAX_HARM)) u_cos_ram (
    .clk(clk), .we(cos_we), .waddr(waddr), .wdata(wrow), .raddr(raddr), .rdata(cos_row)
  );

  fce_ram #(.WIDTH(fce_pkg::ROW_W), .DEPTH(fce_pkg::MAX_HARM)) u_sin_ram (
    .clk(clk), .we(sin_we), .waddr(waddr), .wdata(wrow), .raddr(raddr), .rdata(sin_row)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fce_pkg::S_IDLE:  if (ev_req) state_next = fce_pkg::S_ADDR;
      fce_pkg::S_ADDR:  state_next = (n_reg == 5'd0) ? fce_pkg::S_DRAIN : fce_pkg::S_MUL;
      fce_pkg::S_MUL:   if (c == 2'd2) begin
        state_next = (k == n_reg) ? fce_pkg::S_DRAIN : fce_pkg::S_ADDR;
      end
      fce_pkg::S_DRAIN: if (!(v1 || v2 || v3)) state_next = fce_pkg::S_FLO;
      fce_pkg::S_FLO:   state_next = fce_pkg::S_FHI;
      fce_pkg::S_FHI:   state_next = fce_pkg::S_FCMB;
      fce_pkg::S_FCMB:  state_next = (f == 3'd5) ? fce_pkg::S_OUT : fce_pkg::S_FLO;
      fce_pkg::S_OUT:   state_next = fce_pkg::S_IDLE;
      default:          state_next = fce_pkg::S_IDLE;
    endcase
  end

  // state decode
  always_comb begin
    busy    = (state != fce_pkg::S_IDLE);
    mul_en  = (state == fce_pkg::S_MUL);
    fin_lo  = (state == fce_pkg::S_FLO);
    fin_hi  = (state == fce_pkg::S_FHI);
    fin_cmb = (state == fce_pkg::S_FCMB);
    out_en  = (state == fce_pkg::S_OUT);
  end

  // table lookup operands
  assign spos = pk[fce_pkg::PHASE_BITS-1 -: fce_pkg::POS_W];
  assign cpos = spos + fce_pkg::POS_W'(fce_pkg::SINE_DEPTH);
  assign sv   = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign cv   = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
  assign a_op = cos_ok ? $signed(cos_row[c*32 +: 32]) : 32'sd0;
  assign b_op = sin_ok ? $signed(sin_row[c*32 +: 32]) : 32'sd0;

  assign kd  = fce_pkg::ACC_W'(d3) * fce_pkg::ACC_W'($signed({1'b0, k3}));
  assign kks = fce_pkg::ACC_W'(s3) * fce_pkg::ACC_W'($signed({1'b0, kk3}));

  // final scaling operands
  assign fsel   = (f < 3'd3) ? acct[2'(f)] : acca[2'(f - 3'd3)];
  assign fmag   = fsel[fce_pkg::ACC_W-1] ? fce_pkg::ACC_W'(-fsel) : fce_pkg::ACC_W'(fsel);
  assign fconst = (f < 3'd3) ? fce_pkg::TWO_PI_Q29 : fce_pkg::FOUR_PI2_Q26;
  assign ffull  = {1'b0, fhi, 32'd0} + {25'd0, flo}
                + ((f < 3'd3) ? (89'd1 << (fce_pkg::TAN_SHIFT - 1))
                              : (89'd1 << (fce_pkg::ACC_SHIFT - 1)));
  assign fq     = (f < 3'd3) ? 56'(ffull >> fce_pkg::TAN_SHIFT)
                             : 56'(ffull >> fce_pkg::ACC_SHIFT);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt_sat[i] = fce_pkg::sat_to(fce_pkg::round_away(64'(accp[i]), 8), 40);
      tg_sat[i] = fce_pkg::sat_to(nt[i] ? -$signed({8'd0, qt[i]}) : $signed({8'd0, qt[i]}), 48);
      ac_sat[i] = fce_pkg::sat_to(na[i] ? -$signed({8'd0, qa[i]}) : $signed({8'd0, qa[i]}), 56);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fce_pkg::S_IDLE;
      hiu     <= 5'd0;
      c       <= 2'd0;
      f       <= 3'd0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      done    <= 1'b0;
      cos_vld <= '0;
      sin_vld <= '0;
      for (int i = 0; i < 3; i++) cst[i] <= 32'sd0;
    end else begin
      state <= state_next;
      done  <= out_en;
      v1    <= mul_en;
      v2    <= v1;
      v3    <= v2;
      if (cfg_valid && cfg_ready) hiu <= cfg_data;
      if (cos_we) cos_vld[waddr] <= 1'b1;
      if (sin_we) sin_vld[waddr] <= 1'b1;
      if (wr_req && req.harmonic == 5'd0) begin
        cst[0] <= req.coef_x;
        cst[1] <= req.coef_y;
        cst[2] <= req.coef_z;
      end
      if (ev_req) c <= 2'd0;
      else if (mul_en) c <= (c == 2'd2) ? 2'd0 : c + 2'd1;
      if (ev_req) f <= 3'd0;
      else if (fin_cmb) f <= f + 3'd1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cos_ok  <= cos_vld[raddr];
    sin_ok  <= sin_vld[raddr];
    sin_mag <= fce_pkg::QUARTER[fce_pkg::quarter_index(spos)];
    cos_mag <= fce_pkg::QUARTER[fce_pkg::quarter_index(cpos)];
    sin_neg <= spos[fce_pkg::POS_W-1];
    cos_neg <= cpos[fce_pkg::POS_W-1];

    if (ev_req) begin
      p_reg <= req.phase;
      pk    <= req.phase;
      k     <= 5'd1;
      n_reg <= (hiu > 5'(fce_pkg::MAX_HARM)) ? 5'(fce_pkg::MAX_HARM) : hiu;
      for (int i = 0; i < 3; i++) begin
        accp[i] <= fce_pkg::ACC_W'(cst[i]) <<< 7;
        acct[i] <= '0;
        acca[i] <= '0;
      end
    end else if (v3) begin
      accp[c3] <= accp[c3] + fce_pkg::ACC_W'(s3);
      acct[c3] <= acct[c3] + kd;
      acca[c3] <= acca[c3] + kks;
    end

    if (mul_en && c == 2'd2 && k != n_reg) begin
      k  <= k + 5'd1;
      pk <= pk + p_reg;
    end

    pr_ac <= a_op * cv;
    pr_as <= a_op * sv;
    pr_bc <= b_op * cv;
    pr_bs <= b_op * sv;
    c1    <= c;
    k1    <= k;

    t_ac <= 41'(fce_pkg::round_away(pr_ac, 22));
    t_as <= 41'(fce_pkg::round_away(pr_as, 22));
    t_bc <= 41'(fce_pkg::round_away(pr_bc, 22));
    t_bs <= 41'(fce_pkg::round_away(pr_bs, 22));
    c2   <= c1;
    k2   <= k1;

    s3  <= 42'(t_ac) + 42'(t_bs);
    d3  <= 42'(t_bc) - 42'(t_as);
    c3  <= c2;
    k3  <= k2;
    kk3 <= 10'(k2) * 10'(k2);

    if (fin_lo) flo <= 64'(fmag[31:0]) * 64'(fconst);
    if (fin_hi) fhi <= 56'(fmag[fce_pkg::ACC_W-1:32]) * 56'(fconst);
    if (fin_cmb) begin
      if (f < 3'd3) begin
        qt[2'(f)] <= fq;
        nt[2'(f)] <= fsel[fce_pkg::ACC_W-1];
      end else begin
        qa[2'(f - 3'd3)] <= fq;
        na[2'(f - 3'd3)] <= !fsel[fce_pkg::ACC_W-1];
      end
    end

    if (out_en) begin
      result.point_x   <= pt_sat[0][39:0];
      result.point_y   <= pt_sat[1][39:0];
      result.point_z   <= pt_sat[2][39:0];
      result.tangent_x <= tg_sat[0][47:0];
      result.tangent_y <= tg_sat[1][47:0];
      result.tangent_z <= tg_sat[2][47:0];
      result.accel_x   <= ac_sat[0][55:0];
      result.accel_y   <= ac_sat[1][55:0];
      result.accel_z   <= ac_sat[2][55:0];
    end
  end

  a_done_after_out: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == fce_pkg::S_OUT))
    else $error("done without output state");

  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    wr_req |=> !busy)
    else $error("write request made block busy");

  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == fce_pkg::S_FLO) |-> !(v1 || v2 || v3))
    else $error("scaling started before accumulation drained");

endmodule
